/* rtl/core/nll_pkg.sv */
`timescale 1ns / 1ps
package nll_pkg;

    localparam int VALUE_BITS = 64;
    localparam int LEN_BITS   = 16;

    // phases
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_ZERO     = 4'd1;
    localparam logic [3:0] PH_PREFIX   = 4'd2;
    localparam logic [3:0] PH_DEC      = 4'd3;
    localparam logic [3:0] PH_DOT      = 4'd4;
    localparam logic [3:0] PH_FRAC     = 4'd5;
    localparam logic [3:0] PH_EXP      = 4'd6;
    localparam logic [3:0] PH_EXP_SIGN = 4'd7;
    localparam logic [3:0] PH_EXP_DIG  = 4'd8;
    localparam logic [3:0] PH_SUFFIX   = 4'd9;

    localparam logic [1:0] RX_BIN = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_DEC = 2'd2;
    localparam logic [1:0] RX_HEX = 2'd3;

    localparam logic [1:0] KIND_INT   = 2'd0;
    localparam logic [1:0] KIND_FLOAT = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NO_DIG   = 3'd1;
    localparam logic [2:0] ERR_OVF      = 3'd2;
    localparam logic [2:0] ERR_INT_SFX  = 3'd3;
    localparam logic [2:0] ERR_FLT_SFX  = 3'd4;
    localparam logic [2:0] ERR_EXP      = 3'd5;

    localparam logic [3:0] SFX_NONE = 4'd0;

    // classified character
    typedef struct packed {
        logic [7:0] ch;        // zero for end mark
        logic       is_end;    // end of source, no character
        logic       is_dec;
        logic       is_us;
        logic       is_dot;
        logic       is_e;
        logic       is_sign;
        logic       is_alnum;
        logic       is_iu;
        logic       is_f;
        logic       pfx_ok;    // x/b/o
        logic [1:0] pfx_radix;
        logic       hex_ok;
        logic [3:0] hex_val;
    } t_item;

    function automatic logic [3:0] match_suffix(input logic [2:0] cnt, input logic [31:0] s);
        logic [3:0] code;
        code = SFX_NONE;
        if (cnt == 3'd2) begin
            if (s == {16'h0, "i8"}) code = 4'd1;
            if (s == {16'h0, "u8"}) code = 4'd6;
        end else if (cnt == 3'd3) begin
            if (s == {8'h0, "i16"}) code = 4'd2;
            if (s == {8'h0, "i32"}) code = 4'd3;
            if (s == {8'h0, "i64"}) code = 4'd4;
            if (s == {8'h0, "u16"}) code = 4'd7;
            if (s == {8'h0, "u32"}) code = 4'd8;
            if (s == {8'h0, "u64"}) code = 4'd9;
            if (s == {8'h0, "f32"}) code = 4'd11;
            if (s == {8'h0, "f64"}) code = 4'd12;
        end else if (cnt == 3'd4) begin
            if (s == "i128") code = 4'd5;
            if (s == "u128") code = 4'd10;
        end
        return code;
    endfunction

endpackage

/* rtl/core/nll_front.sv */
`timescale 1ns / 1ps
module nll_front import nll_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_op,
    input  logic  [7:0] i_ch,
    output logic  o_item_valid,
    input  logic  i_item_ready,
    output t_item o_item
);

    t_item      w_item;
    logic [7:0] w_c;
    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_c = i_op ? 8'h00 : i_ch;
        w_item           = '0;
        w_item.ch        = w_c;
        w_item.is_end    = i_op;
        w_item.is_dec    = (w_c >= "0") && (w_c <= "9");
        w_item.is_us     = (w_c == "_");
        w_item.is_dot    = (w_c == ".");
        w_item.is_e      = (w_c == "e") || (w_c == "E");
        w_item.is_sign   = (w_c == "+") || (w_c == "-");
        w_item.is_alnum  = w_item.is_dec || ((w_c >= "a") && (w_c <= "z"))
                           || ((w_c >= "A") && (w_c <= "Z"));
        w_item.is_iu     = (w_c == "i") || (w_c == "u");
        w_item.is_f      = (w_c == "f");
        w_item.pfx_ok    = 1'b1;
        if ((w_c == "x") || (w_c == "X"))      w_item.pfx_radix = RX_HEX;
        else if ((w_c == "b") || (w_c == "B")) w_item.pfx_radix = RX_BIN;
        else if ((w_c == "o") || (w_c == "O")) w_item.pfx_radix = RX_OCT;
        else begin
            w_item.pfx_ok    = 1'b0;
            w_item.pfx_radix = RX_DEC;
        end
        w_item.hex_ok = 1'b1;
        if (w_item.is_dec)                        w_item.hex_val = 4'(w_c - "0");
        else if ((w_c >= "a") && (w_c <= "f"))    w_item.hex_val = 4'(w_c - "a" + 8'd10);
        else if ((w_c >= "A") && (w_c <= "F"))    w_item.hex_val = 4'(w_c - "A" + 8'd10);
        else begin
            w_item.hex_ok  = 1'b0;
            w_item.hex_val = 4'd0;
        end
    end

    assign o_in_ready   = (r_cnt != 2'd2);
    assign w_push       = i_in_valid && o_in_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign w_pop        = o_item_valid && i_item_ready;
    assign o_item       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

/* rtl/core/nll_back.sv */
`timescale 1ns / 1ps
module nll_back import nll_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    output logic  o_item_ready,
    input  t_item i_item,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output logic  [1:0] o_kind,
    output logic  [VALUE_BITS-1:0] o_value,
    output logic  [1:0] o_radix,
    output logic  [3:0] o_suffix_code,
    output logic  [2:0] o_error_code,
    output logic  [LEN_BITS-1:0] o_length
);

    logic [3:0]            r_phase, n_phase;
    logic [1:0]            r_radix, n_radix;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_ovf, n_ovf;
    logic                  r_dig, n_dig;
    logic                  r_dchar, n_dchar;
    logic                  r_flt, n_flt;
    logic [LEN_BITS-1:0]   r_len, n_len;
    logic [31:0]           r_sfx, n_sfx;
    logic [2:0]            r_scnt, n_scnt;
    logic                  r_sfx_f, n_sfx_f;

    logic                  r_ovalid;
    logic [1:0]            r_kind;
    logic [VALUE_BITS-1:0] r_value;
    logic [1:0]            r_oradix;
    logic [3:0]            r_code;
    logic [2:0]            r_err;
    logic [LEN_BITS-1:0]   r_olen;

    logic                  w_go;
    logic                  w_emit;
    logic [1:0]            w_kind;
    logic [VALUE_BITS-1:0] w_value;
    logic [3:0]            w_code;
    logic [2:0]            w_err;
    logic [3:0]            w_ph;
    logic [3:0]            w_d;
    logic                  w_dok;
    logic [VALUE_BITS+3:0] w_ext, w_prod;
    logic [VALUE_BITS-1:0] w_nacc;
    logic                  w_novf;
    logic [LEN_BITS-1:0]   w_len1, w_len2;
    logic [3:0]            w_match;

    assign o_item_ready = !r_ovalid || i_out_ready;
    assign w_go         = i_item_valid && o_item_ready;

    // one shift-add digit step
    always_comb begin
        w_d   = (r_phase == PH_IDLE) ? 4'(i_item.ch - "0") : i_item.hex_val;
        w_ext = {4'd0, r_acc};
        case (r_radix)
            RX_BIN:  w_prod = (w_ext << 1) + (VALUE_BITS+4)'(w_d);
            RX_OCT:  w_prod = (w_ext << 3) + (VALUE_BITS+4)'(w_d);
            RX_HEX:  w_prod = (w_ext << 4) + (VALUE_BITS+4)'(w_d);
            default: w_prod = (w_ext << 3) + (w_ext << 1) + (VALUE_BITS+4)'(w_d);
        endcase
        if (r_phase == PH_IDLE) begin
            w_nacc = VALUE_BITS'(w_d);
            w_novf = 1'b0;
        end else if (r_ovf) begin
            w_nacc = r_acc;
            w_novf = 1'b1;
        end else if (w_prod[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
            w_nacc = r_acc;
            w_novf = 1'b1;
        end else begin
            w_nacc = w_prod[VALUE_BITS-1:0];
            w_novf = 1'b0;
        end
        case (r_radix)
            RX_BIN:  w_dok = i_item.hex_ok && (i_item.hex_val < 4'd2);
            RX_OCT:  w_dok = i_item.hex_ok && (i_item.hex_val < 4'd8);
            RX_DEC:  w_dok = i_item.hex_ok && (i_item.hex_val < 4'd10);
            default: w_dok = i_item.hex_ok;
        endcase
        w_len1  = (r_len == '1) ? r_len : r_len + 1'b1;
        w_len2  = (r_len >= LEN_BITS'(2'd2) - 1'b1 - LEN_BITS'(1'b1) - LEN_BITS'(1'b1) + '1 - LEN_BITS'(1'b1))
                  ? '1 : r_len + LEN_BITS'(2'd2);
        w_match = match_suffix(r_scnt, r_sfx);
    end

    always_comb begin
        n_phase = r_phase; n_radix = r_radix; n_acc = r_acc; n_ovf = r_ovf;
        n_dig = r_dig; n_dchar = r_dchar; n_flt = r_flt; n_len = r_len;
        n_sfx = r_sfx; n_scnt = r_scnt; n_sfx_f = r_sfx_f;
        w_emit = 1'b0; w_kind = KIND_INT; w_value = r_acc; w_code = SFX_NONE;
        w_err = ERR_NONE;
        w_ph = ((r_phase == PH_ZERO) && !i_item.pfx_ok) ? PH_DEC : r_phase;

        case (w_ph)
            PH_IDLE: begin
                if (i_item.is_end) begin
                    // end mark with nothing open
                end else if (!i_item.is_dec) begin
                    w_emit = 1'b1; w_kind = KIND_ERR; w_err = ERR_OVF;
                end else begin
                    n_acc = w_nacc; n_ovf = 1'b0; n_dig = 1'b1; n_dchar = 1'b1;
                    n_len = LEN_BITS'(1'b1);
                    n_phase = (i_item.ch == "0") ? PH_ZERO : PH_DEC;
                end
            end
            PH_ZERO: begin
                n_radix = i_item.pfx_radix; n_dig = 1'b0; n_dchar = 1'b0;
                n_len = w_len1; n_phase = PH_PREFIX;
            end
            PH_PREFIX: begin
                if (w_dok) begin
                    n_acc = w_nacc; n_ovf = w_novf; n_dig = 1'b1; n_dchar = 1'b1;
                    n_len = w_len1;
                end else if (i_item.is_us) begin
                    n_dchar = 1'b1; n_len = w_len1;
                end else if (!r_dchar) begin
                    w_emit = 1'b1; w_kind = KIND_ERR; w_err = ERR_NO_DIG;
                end else if (!r_dig || r_ovf) begin
                    w_emit = 1'b1; w_kind = KIND_ERR; w_err = ERR_OVF;
                end else if (i_item.is_iu) begin
                    n_sfx = {24'd0, i_item.ch}; n_scnt = 3'd1; n_sfx_f = 1'b0;
                    n_len = w_len1; n_phase = PH_SUFFIX;
                end else begin
                    w_emit = 1'b1;
                end
            end
            PH_DEC: begin
                if (i_item.is_dec) begin
                    n_acc = w_nacc; n_ovf = w_novf; n_dig = 1'b1; n_len = w_len1;
                end else if (i_item.is_us) begin
                    n_len = w_len1;
                end else if (i_item.is_dot) begin
                    n_phase = PH_DOT;
                end else if (i_item.is_e) begin
                    n_flt = 1'b1; n_dig = 1'b0; n_len = w_len1; n_phase = PH_EXP;
                end else if (i_item.is_iu || i_item.is_f) begin
                    n_sfx = {24'd0, i_item.ch}; n_scnt = 3'd1; n_sfx_f = i_item.is_f;
                    n_len = w_len1; n_phase = PH_SUFFIX;
                end else if (r_ovf) begin
                    w_emit = 1'b1; w_kind = KIND_ERR; w_err = ERR_OVF;
                end else begin
                    w_emit = 1'b1;
                end
            end
            PH_DOT: begin
                if (i_item.is_dec) begin
                    n_len = w_len2; n_flt = 1'b1; n_phase = PH_FRAC;
                end else if (r_ovf) begin
                    w_emit = 1'b1; w_kind = KIND_ERR; w_err = ERR_OVF;
                end else begin
                    w_emit = 1'b1;
                end
            end
            PH_FRAC, PH_EXP, PH_EXP_SIGN, PH_EXP_DIG: begin
                if ((w_ph == PH_FRAC) && (i_item.is_dec || i_item.is_us)) begin
                    n_len = w_len1;
                end else if ((w_ph == PH_FRAC) && i_item.is_e) begin
                    n_flt = 1'b1; n_dig = 1'b0; n_len = w_len1; n_phase = PH_EXP;
                end else if ((w_ph == PH_EXP) && i_item.is_sign) begin
                    n_len = w_len1; n_phase = PH_EXP_SIGN;
                end else if ((w_ph != PH_FRAC) && (i_item.is_dec || i_item.is_us)) begin
                    n_dig = r_dig || i_item.is_dec; n_len = w_len1; n_phase = PH_EXP_DIG;
                end else if ((w_ph != PH_FRAC) && !((w_ph == PH_EXP_DIG) && r_dig)) begin
                    w_emit = 1'b1; w_kind = KIND_ERR; w_err = ERR_EXP;
                end else if (i_item.is_f) begin
                    n_sfx = {24'd0, i_item.ch}; n_scnt = 3'd1; n_sfx_f = 1'b1;
                    n_len = w_len1; n_phase = PH_SUFFIX;
                end else begin
                    w_emit = 1'b1; w_kind = KIND_FLOAT; w_value = '0;
                end
            end
            PH_SUFFIX: begin
                if (i_item.is_alnum || i_item.is_us) begin
                    if (r_scnt < 3'd4) n_sfx = {r_sfx[23:0], i_item.ch};
                    if (r_scnt != 3'd7) n_scnt = r_scnt + 3'd1;
                    n_len = w_len1;
                end else begin
                    w_emit = 1'b1; w_code = w_match;
                    if (w_match == SFX_NONE) begin
                        w_kind = KIND_ERR;
                        w_err  = r_sfx_f ? ERR_FLT_SFX : ERR_INT_SFX;
                    end else if (r_sfx_f && r_flt) begin
                        w_kind = KIND_FLOAT; w_value = '0;
                    end else if (r_ovf) begin
                        w_kind = KIND_ERR; w_err = ERR_OVF;
                    end else begin
                        w_kind = r_sfx_f ? KIND_FLOAT : KIND_INT;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (w_kind == KIND_ERR) begin
            w_value = '0; w_code = SFX_NONE;
        end
        if (w_emit || (w_ph > PH_SUFFIX)) begin
            n_phase = PH_IDLE; n_radix = RX_DEC; n_acc = '0; n_ovf = 1'b0;
            n_dig = 1'b0; n_dchar = 1'b0; n_flt = 1'b0; n_len = '0;
            n_sfx = '0; n_scnt = 3'd0; n_sfx_f = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_radix <= RX_DEC; r_acc <= '0; r_ovf <= 1'b0;
            r_dig <= 1'b0; r_dchar <= 1'b0; r_flt <= 1'b0; r_len <= '0;
            r_sfx <= '0; r_scnt <= 3'd0; r_sfx_f <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (w_go) begin
                r_phase <= n_phase; r_radix <= n_radix; r_acc <= n_acc; r_ovf <= n_ovf;
                r_dig <= n_dig; r_dchar <= n_dchar; r_flt <= n_flt; r_len <= n_len;
                r_sfx <= n_sfx; r_scnt <= n_scnt; r_sfx_f <= n_sfx_f;
            end
            if (w_go) r_ovalid <= w_emit;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_emit) begin
            r_kind <= w_kind; r_value <= w_value; r_oradix <= r_radix;
            r_code <= w_code; r_err <= w_err; r_olen <= r_len;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_kind        = r_kind;
    assign o_value       = r_value;
    assign o_radix       = r_oradix;
    assign o_suffix_code = r_code;
    assign o_error_code  = r_err;
    assign o_length      = r_olen;

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_kind == KIND_ERR)) |-> ((r_value == '0) && (r_code == SFX_NONE)))
        else $error("error result carries value or suffix");
    a_sfx_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SUFFIX) |-> (r_scnt != 3'd0))
        else $error("suffix phase with no suffix chars");
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> ((r_len == '0) && !r_ovf && (r_radix == RX_DEC)))
        else $error("idle phase with stale token state");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> (r_ovalid && $stable(r_value) && $stable(r_olen)))
        else $error("pending result changed while stalled");

endmodule

/* rtl/core/numeric_literal_lexer_unit.sv */
`timescale 1ns / 1ps
// channel   | valid        | ready        | payload
// ----------+--------------+--------------+-----------------------------------------
// input     | i_in_valid   | o_in_ready   | i_op, i_ch
// output    | o_out_valid  | i_out_ready  | o_kind, o_value, o_radix, o_suffix_code,
//           |              |              | o_error_code, o_length
//
// One request per cycle sustained while the output is not stalled; a result
// is held in the result register once the token's ending character leaves the classify queue.
// Synchronous active-low reset empties the queue and the token state.
// Output stalls back up through the 2-entry queue; input keeps flowing
// while a finished result waits only until that queue is full.
module numeric_literal_lexer_unit import nll_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_op,
    input  logic [7:0]            i_ch,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_kind,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [1:0]            o_radix,
    output logic [3:0]            o_suffix_code,
    output logic [2:0]            o_error_code,
    output logic [LEN_BITS-1:0]   o_length
);

    // classified characters between front and back
    t_item w_item;
    logic  w_item_valid;
    logic  w_item_ready;

    // front: character class decode plus small queue
    nll_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_ch         (i_ch),
        .o_item_valid (w_item_valid),
        .i_item_ready (w_item_ready),
        .o_item       (w_item)
    );

    // back: token state machine, accumulator, result register
    nll_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .o_item_ready  (w_item_ready),
        .i_item        (w_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_radix       (o_radix),
        .o_suffix_code (o_suffix_code),
        .o_error_code  (o_error_code),
        .o_length      (o_length)
    );

endmodule
